>>> src/rdpd_pkg.sv
// Shared types and constants for the rotary dial pulse decoder.
// No dependencies; imported by every module of the block.
package rdpd_pkg;

  localparam int unsigned DebounceW = 10;
  localparam int unsigned TimeW     = 16;
  localparam int unsigned CountW    = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [TimeW-1:0]  TimeMax        = '1;
  localparam logic [CountW-1:0] CountMax       = '1;
  localparam logic [CountW-1:0] TenPulses      = CountW'(10);
  localparam logic [DebounceW-1:0] DebounceRst = DebounceW'(15);
  localparam logic [TimeW-1:0]  DigitEndRst    = TimeW'(600);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEVEL = 2'd1,
    OP_DIGIT = 2'd2,
    OP_RAW   = 2'd3
  } rdpd_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_DIGIT_END = 2'd1,
    REG_FIRST_WIN = 2'd2,
    REG_UNUSED    = 2'd3
  } rdpd_reg_e;

  typedef struct packed {
    rdpd_op_e operation;
    logic     level;
  } rdpd_in_t;

  typedef struct packed {
    logic              ready_res;
    logic              read_ok;
    logic [CountW-1:0] value;
  } rdpd_out_t;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ms;
    logic [TimeW-1:0]     digit_end_ms;
    logic                 first_in_wins;
  } rdpd_cfg_t;

endpackage

>>> src/rdpd_cfg_regs.sv
// Configuration register file of the dial decoder.
// Depends on rdpd_pkg for the register index codes and the config struct.
module rdpd_cfg_regs
  import rdpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  rdpd_reg_e           idx_i,
  input  logic [CfgDataW-1:0] data_i,
  output rdpd_cfg_t           cfg_o
);

  rdpd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        REG_DEBOUNCE:  cfg_d.debounce_ms   = data_i[DebounceW-1:0];
        REG_DIGIT_END: cfg_d.digit_end_ms  = data_i[TimeW-1:0];
        REG_FIRST_WIN: cfg_d.first_in_wins = data_i[0];
        default:       cfg_d = cfg_q; // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.digit_end_ms  <= DigitEndRst;
      cfg_q.first_in_wins <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/rdpd_core.sv
// Decoder state (line level, elapsed ms, pulse count) and its one-step update.
// Depends on rdpd_pkg; driven from the input register of the top level.
module rdpd_core
  import rdpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  rdpd_in_t  req_i,
  input  rdpd_cfg_t cfg_i,
  output rdpd_out_t res_o
);

  logic              line_q, line_d;
  logic [TimeW-1:0]  ms_q, ms_d;
  logic [CountW-1:0] tot_q, tot_d;
  logic [CountW-1:0] tot_base;
  logic              waiting;

  // digit complete: pulses seen and line quiet long enough
  assign waiting = (tot_q != '0) && (ms_q > cfg_i.digit_end_ms);

  always_comb begin
    line_d        = line_q;
    ms_d          = ms_q;
    tot_d         = tot_q;
    tot_base      = waiting ? '0 : tot_q;
    res_o.read_ok = 1'b0;
    res_o.value   = '0;
    unique case (req_i.operation) inside
      OP_TICK: begin
        if (ms_q != TimeMax) ms_d = ms_q + TimeW'(1);
      end
      OP_LEVEL: begin
        if (req_i.level != line_q) begin
          line_d = req_i.level;
          if (!(waiting && cfg_i.first_in_wins)) begin
            tot_d = tot_base;
            if (req_i.level) begin
              ms_d = '0;
            end else if (ms_q > TimeW'(cfg_i.debounce_ms) && tot_base != CountMax) begin
              tot_d = tot_base + CountW'(1);
            end
          end
        end
      end
      OP_DIGIT, OP_RAW: begin
        if (waiting) begin
          res_o.read_ok = 1'b1;
          tot_d         = '0;
          if (req_i.operation == OP_DIGIT && tot_q == TenPulses) res_o.value = '0;
          else res_o.value = tot_q;
        end
      end
      default: ;
    endcase
    res_o.ready_res = (tot_d != '0) && (ms_d > cfg_i.digit_end_ms);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= 1'b0;
      ms_q   <= '0;
      tot_q  <= '0;
    end else if (en_i) begin
      line_q <= line_d;
      ms_q   <= ms_d;
      tot_q  <= tot_d;
    end
  end

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(ms_q) && $stable(tot_q) && $stable(line_q))
    else $error("decoder state moved without a request");

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.read_ok |=> tot_q == '0)
    else $error("pulse count not cleared by a read");

  a_read_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res_o.read_ok |-> !res_o.ready_res)
    else $error("digit still flagged after a successful read");

  a_tick_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && req_i.operation == OP_TICK |=>
      ms_q == $past(ms_q) + TimeW'(1) || ms_q == TimeMax)
    else $error("tick did not advance elapsed time");

endmodule

>>> src/rotary_dial_pulse_decoder.sv
// Top level of the rotary dial pulse decoder: input register, decode core,
// result register. Depends on rdpd_pkg, rdpd_cfg_regs and rdpd_core.
//
// Usage
//   in_*   : one request per accepted beat: a 1 ms tick, a line level sample,
//            a digit read or a raw pulse-count read (in_data_i).
//   out_*  : exactly one result per request, in order: ready_res, read_ok,
//            value (digit with ten pulses as 0, or raw count).
//   cfg_*  : register writes (0 debounce_ms, 1 digit_end_ms, 2 first_in_wins);
//            always ready, unmapped index is dropped. Write only when idle.
// Timing
//   A request is captured in the input register, then the core updates its
//   state and the result is captured in the output register. Throughput is
//   one request per cycle while the result side is ready (out_ready_i high);
//   the core's single compare/increment step per request sets that.
// Reset
//   Async active-low. Clears pipeline valids, the line level, elapsed time and
//   pulse count; config returns to 15 ms debounce, 600 ms digit end, last-in-wins.
// Stall
//   When out_ready_i is low the result holds; the input register still fills,
//   then in_ready_o drops until the result is taken. No request is lost.
module rotary_dial_pulse_decoder
  import rdpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rdpd_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rdpd_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  rdpd_cfg_t cfg;
  rdpd_out_t res;

  logic      req_valid_q;
  rdpd_in_t  req_q;
  logic      out_valid_q;
  rdpd_out_t out_q;
  logic      step;     // core consumes the buffered request this cycle
  logic      out_free; // result register can take a new value

  assign cfg_ready_o = 1'b1;

  rdpd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i),
    .idx_i  (rdpd_reg_e'(cfg_index_i)),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = req_valid_q && out_free;
  assign in_ready_o = !req_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) req_q <= in_data_i;
  end

  rdpd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rotary_dial_pulse_decoder: dial pulse trains, noise
// and register settings in, results checked against an in-bench predictor.
// Depends on rdpd_pkg and the decoder RTL only.
module tb;
  import rdpd_pkg::*;

  localparam int unsigned RandomItems   = 1000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PrintCap      = 50;

  // Predicts every result from the requests accepted so far; keeps its own
  // copy of the line state and the register settings.
  class dial_tracker;
    rdpd_cfg_t         settings;
    logic              line_hi;
    logic [TimeW-1:0]  quiet_ms;
    logic [CountW-1:0] pulse_cnt;
    rdpd_out_t         pending_reports[$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       reports_seen;
    int unsigned       digits_taken;

    function new();
      settings.debounce_ms   = DebounceRst;
      settings.digit_end_ms  = DigitEndRst;
      settings.first_in_wins = 1'b0;
      line_hi      = 1'b0;
      quiet_ms     = '0;
      pulse_cnt    = '0;
      errors       = 0;
      requests     = 0;
      reports_seen = 0;
      digits_taken = 0;
    endfunction

    function bit digit_complete();
      return pulse_cnt != '0 && quiet_ms > settings.digit_end_ms;
    endfunction

    function void write_reg(rdpd_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_DEBOUNCE:  settings.debounce_ms = data[DebounceW-1:0];
        REG_DIGIT_END: settings.digit_end_ms = data[TimeW-1:0];
        REG_FIRST_WIN: settings.first_in_wins = data[0];
        default: ;
      endcase
    endfunction

    function void apply_level(logic lv);
      if (lv == line_hi) return;
      line_hi = lv;
      // an edge on top of an unread digit
      if (digit_complete()) begin
        if (settings.first_in_wins) return;
        pulse_cnt = '0;
      end
      if (lv) begin
        quiet_ms = '0;
      end else if (quiet_ms > settings.debounce_ms && pulse_cnt != CountMax) begin
        pulse_cnt = pulse_cnt + 1'b1;
      end
    endfunction

    function void take_request(rdpd_in_t req);
      rdpd_out_t rsp;
      rsp = '0;
      requests++;
      case (req.operation)
        OP_TICK: begin
          if (quiet_ms != TimeMax) quiet_ms = quiet_ms + 1'b1;
        end
        OP_LEVEL: apply_level(req.level);
        default: begin
          if (digit_complete()) begin
            rsp.read_ok = 1'b1;
            rsp.value   = pulse_cnt;
            pulse_cnt   = '0;
            if (req.operation == OP_DIGIT && rsp.value == TenPulses) rsp.value = '0;
            digits_taken++;
          end
        end
      endcase
      rsp.ready_res = digit_complete();
      pending_reports.push_back(rsp);
    endfunction

    function void match_report(rdpd_out_t got);
      rdpd_out_t want;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= PrintCap)
          $display("%0t: unexpected result, expected none, got %h", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      if (got.ready_res !== want.ready_res) begin
        errors++;
        if (errors <= PrintCap)
          $display("%0t: ready_res expected %0b got %0b", $time, want.ready_res, got.ready_res);
      end
      if (got.read_ok !== want.read_ok) begin
        errors++;
        if (errors <= PrintCap)
          $display("%0t: read_ok expected %0b got %0b", $time, want.read_ok, got.read_ok);
      end
      if (got.value !== want.value) begin
        errors++;
        if (errors <= PrintCap)
          $display("%0t: value expected %0d got %0d", $time, want.value, got.value);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  rdpd_in_t            in_data   = '0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_ready;
  logic                out_valid;
  rdpd_out_t           out_data;
  logic                cfg_ready;

  bit          calm        = 1'b0;  // no idling on either side
  bit          hold_off_go = 1'b0;
  int unsigned reg_writes  = 0;
  dial_tracker sb          = new();

  rotary_dial_pulse_decoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are sampled here with their pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_request(in_data);
      if (out_valid && out_ready) sb.match_report(out_data);
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HoldOffCycles; n++) @(posedge clk);
        out_ready <= 1'b1;
        hold_off_go = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 6);
      end
    end
  end

  // Watchdog: too long without any accepted request, result or write.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no handshake for %0d cycles", WatchdogLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_request(rdpd_op_e op, logic lv);
    rdpd_in_t req;
    req.operation = op;
    req.level     = lv;
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic tick(int unsigned n);
    repeat (n) send_request(OP_TICK, 1'b0);
  endtask

  task automatic read_count();
    send_request(($urandom_range(1) != 0) ? OP_DIGIT : OP_RAW, 1'($urandom));
  endtask

  // Pulse train; bouncy trains have some highs too short to count.
  task automatic dial_digit(int unsigned pulses, bit bouncy);
    int unsigned db;
    int unsigned hi;
    db = sb.settings.debounce_ms;
    for (int unsigned i = 0; i < pulses; i++) begin
      if (bouncy && $urandom_range(3) == 0) hi = $urandom_range(db);
      else hi = db + 1 + $urandom_range(2);
      send_request(OP_LEVEL, 1'b1);
      tick(hi);
      send_request(OP_LEVEL, 1'b0);
      tick($urandom_range(2));
    end
  endtask

  // Enough quiet after the last rise to close the digit.
  task automatic rest_quiet();
    tick(sb.settings.digit_end_ms + 1 + $urandom_range(3));
  endtask

  // Sender pause until every expected result is back; the block is idle then.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(rdpd_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int unsigned db, int unsigned de, bit fiw);
    write_reg(REG_DEBOUNCE, {6'($urandom), 10'(db)});
    write_reg(REG_DIGIT_END, 16'(de));
    write_reg(REG_FIRST_WIN, {15'($urandom), fiw});
  endtask

  task automatic random_episode();
    int unsigned kind;
    int unsigned pulses;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // mostly well-formed dialing with random content
      pulses = ($urandom_range(9) == 0) ? $urandom_range(34, 13) : $urandom_range(12, 1);
      dial_digit(pulses, $urandom_range(4) == 0);
      if ($urandom_range(4) == 0) read_count();
      rest_quiet();
      if ($urandom_range(5) == 0) begin
        // edges on top of the unread digit
        dial_digit($urandom_range(3, 1), 1'b0);
        if ($urandom_range(1) != 0) rest_quiet();
      end
      read_count();
      if ($urandom_range(3) == 0) read_count();
    end else if (kind < 90) begin
      repeat ($urandom_range(10, 3)) send_request(rdpd_op_e'($urandom_range(3)), 1'($urandom));
    end else begin
      tick($urandom_range(40));
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned phase;
    int unsigned db;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 15 ms debounce, 600 ms digit end, last-in-wins.
    send_request(OP_LEVEL, 1'b1);
    tick(15);
    send_request(OP_LEVEL, 1'b0);   // exactly the debounce time: no pulse
    send_request(OP_LEVEL, 1'b1);
    tick(16);
    send_request(OP_LEVEL, 1'b0);   // counts
    tick(600);
    read_count();                   // 616 ms since the rise: already past the digit end
    tick(1);
    send_request(OP_DIGIT, 1'b0);
    drain();

    // Short directed pass: empty reads, repeated levels, bounce, one pulse.
    write_reg(REG_DEBOUNCE, 16'hFC02);
    write_reg(REG_DIGIT_END, 16'd3);
    write_reg(REG_FIRST_WIN, 16'hFFFE);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_request(OP_DIGIT, 1'b1);
    send_request(OP_RAW, 1'b0);
    send_request(OP_LEVEL, 1'b0);
    tick(1);
    send_request(OP_LEVEL, 1'b1);
    send_request(OP_LEVEL, 1'b1);
    tick(2);
    send_request(OP_LEVEL, 1'b0);
    send_request(OP_LEVEL, 1'b1);
    tick(3);
    send_request(OP_LEVEL, 1'b0);
    tick(1);
    send_request(OP_DIGIT, 1'b0);
    send_request(OP_RAW, 1'b1);
    drain();

    // Ten pulses read as digit 0, eleven stay eleven, raw read of ten.
    set_regs(1, 40, 1'b0);
    dial_digit(10, 1'b0);
    rest_quiet();
    send_request(OP_DIGIT, 1'b0);
    dial_digit(11, 1'b0);
    rest_quiet();
    send_request(OP_DIGIT, 1'b0);
    dial_digit(10, 1'b0);
    rest_quiet();
    send_request(OP_RAW, 1'b0);
    drain();

    // Pulse count saturates at 31.
    set_regs(0, 5, 1'b0);
    dial_digit(33, 1'b0);
    tick(6);
    send_request(OP_RAW, 1'b0);
    drain();

    // Both edge policies on an unread digit.
    set_regs(2, 10, 1'b1);
    dial_digit(3, 1'b0);
    rest_quiet();
    dial_digit(2, 1'b0);
    rest_quiet();
    send_request(OP_DIGIT, 1'b0);
    drain();
    write_reg(REG_FIRST_WIN, 16'h0000);
    dial_digit(3, 1'b0);
    rest_quiet();
    dial_digit(2, 1'b0);
    rest_quiet();
    send_request(OP_DIGIT, 1'b0);
    drain();

    // Largest debounce with upper data bits set; zero digit end.
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_DIGIT_END, 16'h0000);
    send_request(OP_LEVEL, 1'b1);
    tick(1023);
    send_request(OP_LEVEL, 1'b0);
    send_request(OP_LEVEL, 1'b1);
    tick(1024);
    send_request(OP_LEVEL, 1'b0);
    send_request(OP_DIGIT, 1'b0);
    drain();

    // Elapsed time saturates; a digit end of 65535 never closes the digit.
    set_regs(0, 16'hFFFF, 1'b0);
    send_request(OP_LEVEL, 1'b1);
    tick(1);
    send_request(OP_LEVEL, 1'b0);
    tick(65540);
    send_request(OP_DIGIT, 1'b0);
    drain();
    write_reg(REG_DIGIT_END, 16'hFFFE);
    write_reg(REG_UNUSED, 16'h0000);
    tick(1);
    send_request(OP_DIGIT, 1'b0);
    send_request(OP_RAW, 1'b0);
    drain();

    // Random phases, fresh settings each time the block is idle.
    base  = sb.requests;
    phase = 0;
    while (sb.requests - base < RandomItems) begin
      drain();
      calm = (phase == 0);
      db = (phase == 1) ? 0 : $urandom_range(6);
      if (phase % 5 == 3) set_regs(db, 0, 1'($urandom));
      else set_regs(db, db + 3 + $urandom_range(20), 1'($urandom));
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 16'($urandom));
      for (int e = 0; e < 6; e++) begin
        if (phase == 1 && e == 2) hold_off_go = 1'b1;  // sender keeps going
        if (phase == 2 && e == 3) drain();
        random_episode();
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending_reports.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.pending_reports.size());
    end
    $display("run: %0d requests, %0d results checked, %0d counts read, %0d register writes",
             sb.requests, sb.reports_seen, sb.digits_taken, reg_writes);
    $display("covered: reset settings, bounce, ten pulses, saturation, edge policies, stalls");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
